// ===== rtl/sdh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdh_pkg
// Shared types and constants for the stepper distance homing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdh_pkg;

    // Operating modes, also driven out as the status field.
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_SETTLE = 3'd1;
    localparam logic [2:0] MODE_FWD    = 3'd2;
    localparam logic [2:0] MODE_BACK   = 3'd3;
    localparam logic [2:0] MODE_WAIT   = 3'd4;
    localparam logic [2:0] MODE_DONE   = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] NEAR_LIMIT_RST   = 16'd100;
    localparam logic [7:0]  WINDOW_WIDTH_RST = 8'd7;
    localparam logic [15:0] FAR_LIMIT_RST    = 16'd240;
    localparam logic [7:0]  STEP_TICKS_RST   = 8'd3;
    localparam logic [15:0] SETTLE_TICKS_RST = 16'd3000;

    typedef struct packed {
        logic [15:0] near_limit;
        logic [7:0]  window_width;
        logic [15:0] far_limit;
        logic [7:0]  step_ticks;
        logic [15:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0] coils;
        logic [2:0] status;
        logic       done_res;
    } res_t;

    // Two-phase-on full step patterns, bit 0 is the first winding.
    // The reverse sequence is the forward one read from the far end.
    function automatic logic [3:0] step_pattern(input logic back, input logic [1:0] idx);
        logic [1:0] i;
        logic [3:0] pat;
        i = back ? ~idx : idx;
        unique case (i)
            2'd0: pat = 4'h3;
            2'd1: pat = 4'h6;
            2'd2: pat = 4'hC;
            2'd3: pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdh_core.sv =====
// ----------------------------------------------------------------------------
// sdh_core
// Homing sequencer: settle wait, distance decision and coil stepping.
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_core
    import sdh_pkg::*;
#(
    parameter int unsigned DIST_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 step_en,
    input  wire logic                 cmd,
    input  wire logic [DIST_BITS-1:0] distance,
    output res_t                      res
);

    // Comparison width covers the distance and near_limit + window_width.
    localparam int unsigned CMP_W = (DIST_BITS > 17) ? DIST_BITS : 17;

    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] tick_reg,  tick_next;
    logic [1:0]  phase_reg, phase_next;
    logic        dir_reg,   dir_next;
    logic [3:0]  coil_reg,  coil_next;

    logic [CMP_W-1:0] dist_ext;
    logic [CMP_W-1:0] near_ext;
    logic [CMP_W-1:0] upper_ext;
    logic [CMP_W-1:0] far_ext;
    logic [15:0]      hold_len;
    logic             decide;
    logic             done;

    assign dist_ext  = CMP_W'(distance);
    assign near_ext  = CMP_W'(cfg.near_limit);
    assign upper_ext = CMP_W'(cfg.near_limit) + CMP_W'(cfg.window_width);
    assign far_ext   = CMP_W'(cfg.far_limit);
    assign hold_len  = (cfg.step_ticks == 8'd0) ? 16'd1 : 16'(cfg.step_ticks);

    always_comb begin
        mode_next  = mode_reg;
        tick_next  = tick_reg;
        phase_next = phase_reg;
        dir_next   = dir_reg;
        coil_next  = coil_reg;
        decide     = 1'b0;
        done       = 1'b0;

        if (cmd) begin
            mode_next = MODE_SETTLE;
            tick_next = 16'd0;
        end else begin
            unique case (mode_reg)
                MODE_SETTLE: begin
                    if (tick_reg >= cfg.settle_ticks) begin
                        decide = 1'b1;
                    end else begin
                        tick_next = tick_reg + 16'd1;
                    end
                end
                MODE_FWD, MODE_BACK: begin
                    if (tick_reg < hold_len) begin
                        tick_next = tick_reg + 16'd1;
                    end else if (phase_reg == 2'd3) begin
                        decide = 1'b1;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                        tick_next  = 16'd1;
                        coil_next  = step_pattern(dir_reg, phase_reg + 2'd1);
                    end
                end
                MODE_WAIT: decide = 1'b1;
                default: ;
            endcase

            // One decision per sample; the window wins over the far bound.
            if (decide) begin
                priority if (dist_ext < near_ext) begin
                    mode_next  = MODE_FWD;
                    dir_next   = 1'b0;
                    phase_next = 2'd0;
                    tick_next  = 16'd1;
                    coil_next  = step_pattern(1'b0, 2'd0);
                end else if (dist_ext <= upper_ext) begin
                    mode_next = MODE_DONE;
                    done      = 1'b1;
                end else if (dist_ext == far_ext) begin
                    mode_next = MODE_WAIT;
                end else begin
                    mode_next  = MODE_BACK;
                    dir_next   = 1'b1;
                    phase_next = 2'd0;
                    tick_next  = 16'd1;
                    coil_next  = step_pattern(1'b1, 2'd0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            tick_reg  <= 16'd0;
            phase_reg <= 2'd0;
            dir_reg   <= 1'b0;
            coil_reg  <= 4'h0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            coil_reg  <= coil_next;
        end
    end

    assign res.coils    = coil_next;
    assign res.status   = mode_next;
    assign res.done_res = done;

    // Stepping modes always have a live pattern on the coils.
    a_step_has_coils: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_FWD || mode_reg == MODE_BACK) |-> (coil_reg != 4'h0))
        else $error("stepping with all coils off");

    // The stored direction matches the stepping mode.
    a_dir_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_FWD || mode_reg == MODE_BACK) |->
        (dir_reg == (mode_reg == MODE_BACK)))
        else $error("direction flag disagrees with mode");

    // Every pattern on the coils has begun its hold, so the counter is never zero.
    a_hold_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_FWD || mode_reg == MODE_BACK) |-> (tick_reg != 16'd0))
        else $error("hold counter out of range");

endmodule

`default_nettype wire

// ===== rtl/stepper_distance_homing_unit.sv =====
// An accepted request waits in the input register; the sequencer result for it
// is registered in the result register, which drives m_tvalid, once that slot frees.
// Throughput: one request per cycle while results are taken; the result
// register frees as it is taken, and the sequencer update is combinational.
// Reset: aresetn low clears both stages, the sequencer to idle with coils off,
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// stepper_distance_homing_unit
// Stream wrapper, configuration registers and result staging around the
// homing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_distance_homing_unit
    import sdh_pkg::*;
#(
    parameter int unsigned DIST_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [((DIST_BITS+7)/8)*8-1:0] s_tdata,  // [DIST_BITS-1:0] distance
    input  wire logic                          s_tuser,  // [0] cmd

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // [3:0] coils, [6:4] status,
                                                         // [7] done_res

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    cfg_t cfg_reg;

    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic [DIST_BITS-1:0] in_dist_reg;

    logic       out_valid_reg;
    res_t       out_res_reg;
    res_t       core_res;
    logic       advance;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit   <= NEAR_LIMIT_RST;
            cfg_reg.window_width <= WINDOW_WIDTH_RST;
            cfg_reg.far_limit    <= FAR_LIMIT_RST;
            cfg_reg.step_ticks   <= STEP_TICKS_RST;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NEAR_LIMIT:   cfg_reg.near_limit   <= cfg_data;
                CFG_WINDOW_WIDTH: cfg_reg.window_width <= cfg_data[7:0];
                CFG_FAR_LIMIT:    cfg_reg.far_limit    <= cfg_data;
                CFG_STEP_TICKS:   cfg_reg.step_ticks   <= cfg_data[7:0];
                CFG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // The request in the input register moves on when the result slot is free or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_dist_reg <= s_tdata[DIST_BITS-1:0];
        end
    end

    sdh_core #(
        .DIST_BITS (DIST_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .step_en  (advance),
        .cmd      (in_cmd_reg),
        .distance (in_dist_reg),
        .res      (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.done_res, out_res_reg.status, out_res_reg.coils};

    // A done pulse is only ever reported together with the done status.
    a_done_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.done_res) |-> (out_res_reg.status == MODE_DONE))
        else $error("done pulse without done status");

    // Coils show either nothing or two adjacent windings.
    a_coil_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res_reg.coils == 4'h0 || out_res_reg.coils == 4'h3 ||
                      out_res_reg.coils == 4'h6 || out_res_reg.coils == 4'hC ||
                      out_res_reg.coils == 4'h9))
        else $error("illegal coil pattern");

    // A buffered request that cannot move on is kept.
    a_in_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("buffered request lost");

    // A request only advances into a result slot that is free or being drained.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== test/homing_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homing_checker
// Watches the request, result and configuration channels of the homing unit.
// Keeps its own copy of the sequencer and its settings, works out the result
// of every accepted request, and compares the results in order as they leave.
// ----------------------------------------------------------------------------
module homing_checker
    import sdh_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [15:0]           s_tdata,   // [15:0] distance
    input  wire logic                  s_tuser,   // [0] cmd

    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata,   // [3:0] coils, [6:4] status, [7] done_res

    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    output int                         fail_count,
    output int                         pending
);

    cfg_t        cfg_copy;
    logic [2:0]  mode;
    logic [15:0] tick_cnt;
    logic [1:0]  phase;
    logic        back;
    logic [3:0]  coils;
    res_t        expected_steps[$];

    // Forward run is 3, 6, C, 9; the reverse run walks the same list backward.
    function automatic logic [3:0] coil_for(input logic rev, input logic [1:0] idx);
        logic [1:0] pos;
        pos = rev ? 2'd3 - idx : idx;
        case (pos)
            2'd0:    return 4'h3;
            2'd1:    return 4'h6;
            2'd2:    return 4'hC;
            default: return 4'h9;
        endcase
    endfunction

    // One decision on a distance sample; returns 1 when the window is reached.
    function automatic logic judge_distance(input logic [15:0] sample);
        logic [16:0] upper;
        upper = {1'b0, cfg_copy.near_limit} + {9'd0, cfg_copy.window_width};
        if (sample < cfg_copy.near_limit) begin
            mode = MODE_FWD;
            back = 1'b0;
        end else if ({1'b0, sample} <= upper) begin
            mode = MODE_DONE;
            return 1'b1;
        end else if (sample == cfg_copy.far_limit) begin
            mode = MODE_WAIT;
            return 1'b0;
        end else begin
            mode = MODE_BACK;
            back = 1'b1;
        end
        phase    = 2'd0;
        tick_cnt = 16'd1;
        coils    = coil_for(back, 2'd0);
        return 1'b0;
    endfunction

    task automatic advance_homing(input logic cmd, input logic [15:0] sample,
                                  output res_t step);
        logic        reached;
        logic [15:0] hold;
        reached = 1'b0;
        // A hold time of zero behaves as one tick.
        hold = (cfg_copy.step_ticks == 8'd0) ? 16'd1 : {8'd0, cfg_copy.step_ticks};
        if (cmd) begin
            mode     = MODE_SETTLE;
            tick_cnt = 16'd0;
        end else begin
            case (mode)
                MODE_SETTLE: begin
                    if (tick_cnt >= cfg_copy.settle_ticks) begin
                        reached = judge_distance(sample);
                    end else begin
                        tick_cnt = tick_cnt + 16'd1;
                    end
                end
                MODE_FWD, MODE_BACK: begin
                    if (tick_cnt < hold) begin
                        tick_cnt = tick_cnt + 16'd1;
                    end else if (phase == 2'd3) begin
                        reached = judge_distance(sample);
                    end else begin
                        phase    = phase + 2'd1;
                        tick_cnt = 16'd1;
                        coils    = coil_for(back, phase);
                    end
                end
                MODE_WAIT: begin
                    reached = judge_distance(sample);
                end
                default: ;
            endcase
        end
        step.coils    = coils;
        step.status   = mode;
        step.done_res = reached;
    endtask

    always @(posedge aclk) begin : watch
        res_t want;
        res_t got;
        if (!aresetn) begin
            cfg_copy.near_limit   = NEAR_LIMIT_RST;
            cfg_copy.window_width = WINDOW_WIDTH_RST;
            cfg_copy.far_limit    = FAR_LIMIT_RST;
            cfg_copy.step_ticks   = STEP_TICKS_RST;
            cfg_copy.settle_ticks = SETTLE_TICKS_RST;
            mode     = MODE_IDLE;
            tick_cnt = 16'd0;
            phase    = 2'd0;
            back     = 1'b0;
            coils    = 4'h0;
            expected_steps.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NEAR_LIMIT:   cfg_copy.near_limit   = cfg_data[15:0];
                    CFG_WINDOW_WIDTH: cfg_copy.window_width = cfg_data[7:0];
                    CFG_FAR_LIMIT:    cfg_copy.far_limit    = cfg_data[15:0];
                    CFG_STEP_TICKS:   cfg_copy.step_ticks   = cfg_data[7:0];
                    CFG_SETTLE_TICKS: cfg_copy.settle_ticks = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.coils    = m_tdata[3:0];
                got.status   = m_tdata[6:4];
                got.done_res = m_tdata[7];
                if (expected_steps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"homing_checker: result with none expected:",
                                  " coils %h status %0d done %b"},
                                 got.coils, got.status, got.done_res);
                end else begin
                    want = expected_steps.pop_front();
                    if (got.coils != want.coils || got.status != want.status ||
                        got.done_res != want.done_res) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"homing_checker: mismatch at %0t: expected coils %h status %0d",
                                      " done %b, got coils %h status %0d done %b"},
                                     $realtime, want.coils, want.status, want.done_res,
                                     got.coils, got.status, got.done_res);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_homing(s_tuser, s_tdata, want);
                expected_steps.push_back(want);
            end
        end
        pending = expected_steps.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the stepper distance homing unit with directed homing runs that hit
// the window edges, the far bound and restarts, then with random runs under
// several settings and flow-control patterns. A separate checker predicts and
// compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import sdh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = 16'd0;  // [15:0] distance
    logic                  s_tuser   = 1'b0;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;            // [3:0] coils, [6:4] status, [7] done_res
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_NEAR_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    cfg_t stim_cfg;

    always #2 aclk = ~aclk;

    stepper_distance_homing_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    homing_checker watch_u (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // A toggle of hold_kick starts one long hold-off of the result side.
    always @(posedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[stepper_distance_homing_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [15:0] sample);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= sample;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Returns on a rising edge once every expected result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] near, input logic [7:0] win,
                              input logic [15:0] far, input logic [7:0] step,
                              input logic [15:0] settle);
        wait_drained();
        stim_cfg.near_limit   = near;
        stim_cfg.window_width = win;
        stim_cfg.far_limit    = far;
        stim_cfg.step_ticks   = step;
        stim_cfg.settle_ticks = settle;
        write_reg(CFG_NEAR_LIMIT, near);
        write_reg(CFG_WINDOW_WIDTH, {8'd0, win});
        write_reg(CFG_FAR_LIMIT, far);
        write_reg(CFG_STEP_TICKS, {8'd0, step});
        write_reg(CFG_SETTLE_TICKS, settle);
        cfg_valid <= 1'b0;
    endtask

    // Spread samples over the regions that steer the decision.
    function automatic logic [15:0] pick_distance();
        logic [31:0] k;
        logic [31:0] near_v;
        logic [31:0] upper;
        logic [31:0] v;
        near_v = stim_cfg.near_limit;
        upper  = near_v + stim_cfg.window_width;
        k      = $urandom_range(99);
        if (k < 25 && near_v > 0) begin
            v = $urandom_range(near_v - 1, 0);
        end else if (k < 45) begin
            v = near_v + $urandom_range(stim_cfg.window_width);
            if (v > 32'hFFFF) v = 32'hFFFF;
        end else if (k < 60) begin
            v = stim_cfg.far_limit;
        end else if (k < 85 && upper < 32'hFFFF) begin
            v = $urandom_range(32'hFFFF, upper + 1);
        end else begin
            v = $urandom;
        end
        return v[15:0];
    endfunction

    // Mostly clean homing runs (a start and a stretch of ticks), with the
    // occasional run that has no start and stray restarts among the ticks.
    task automatic run_phase(input int n_items, input logic with_pressure);
        int   sent;
        int   len;
        int   k;
        logic kicked;
        sent   = 0;
        kicked = 1'b0;
        while (sent < n_items) begin
            if ($urandom_range(9) != 0) begin
                send_item(1'b1, pick_distance());
                sent++;
            end
            len = $urandom_range(40, 4);
            for (k = 0; k < len && sent < n_items; k++) begin
                if (with_pressure && !kicked && sent >= 40) begin
                    hold_kick <= ~hold_kick;
                    kicked = 1'b1;
                end
                send_item($urandom_range(19) == 0, pick_distance());
                sent++;
            end
        end
    endtask

    initial begin
        stim_cfg.near_limit   = NEAR_LIMIT_RST;
        stim_cfg.window_width = WINDOW_WIDTH_RST;
        stim_cfg.far_limit    = FAR_LIMIT_RST;
        stim_cfg.step_ticks   = STEP_TICKS_RST;
        stim_cfg.settle_ticks = SETTLE_TICKS_RST;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a tick while idle, then a start that keeps settling.
        send_item(1'b0, 16'h0000);
        send_item(1'b1, 16'hFFFF);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b0, 16'h0000);

        // No settle time and a zero hold, so every tick moves one pattern.
        set_config(16'd20, 8'd0, 16'd50, 8'd0, 16'd0);
        send_item(1'b1, 16'h1234);
        send_item(1'b0, 16'd5);
        send_item(1'b0, 16'd5);
        send_item(1'b0, 16'd5);
        send_item(1'b0, 16'd5);
        send_item(1'b0, 16'd20);     // lands exactly on a one-value window
        send_item(1'b0, 16'd0);      // done ignores ticks
        send_item(1'b1, 16'd0);
        send_item(1'b0, 16'd50);     // on the far bound: wait, no step
        send_item(1'b0, 16'd50);
        send_item(1'b0, 16'hFFFF);   // backward run
        send_item(1'b0, 16'd0);
        send_item(1'b1, 16'd0);      // restart in the middle of a run
        send_item(1'b0, 16'd0);

        // The window reaches the top of the range and covers the far bound.
        set_config(16'hFF00, 8'd255, 16'hFFFF, 8'd255, 16'd2);
        send_item(1'b1, 16'd0);
        send_item(1'b0, 16'd0);
        send_item(1'b0, 16'd0);
        send_item(1'b0, 16'hFFFF);

        set_config(16'd0, 8'd255, 16'd0, 8'd255, 16'hFFFF);
        send_item(1'b1, 16'd0);
        send_item(1'b0, 16'd0);
        send_item(1'b0, 16'hFFFF);

        set_config(16'd1000, 8'd15, 16'd2000, 8'd2, 16'd3);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_phase(115, 1'b1);

        set_config(16'd0, 8'd255, 16'd0, 8'd1, 16'd0);
        sender_idle_pct = 85;
        recv_stall_pct  = 0;
        run_phase(115, 1'b0);

        set_config(16'hFFFF, 8'd0, 16'hFFFF, 8'd4, 16'd1);
        sender_idle_pct = 0;
        recv_stall_pct  = 85;
        run_phase(110, 1'b0);

        set_config(16'd300, 8'd40, 16'd400, 8'd0, 16'd5);
        sender_idle_pct = 12;
        recv_stall_pct  = 12;
        run_phase(110, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("[stepper_distance_homing_unit] OK");
        else
            $display("[stepper_distance_homing_unit] ERROR");
        $finish;
    end

endmodule
